>>> rtl/core/gfa_pkg.sv
// ----------------------------------------------------------------------------
// gfa_pkg: shared types, constants and microcode for the GF(2^45) field ALU
// Field element widths, the control word layout, the program ROM and the
// entry point of each operation's program.
// ----------------------------------------------------------------------------
package gfa_pkg;

    localparam int ELEM_W     = 45;
    localparam int HALF_LO_W  = 23;
    localparam int HALF_HI_W  = ELEM_W - HALF_LO_W;
    localparam int PP_W       = ELEM_W + HALF_LO_W - 1;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int INV_ROUNDS = 43;
    localparam int CNT_W      = 6;
    localparam int UPC_W      = 5;

    typedef logic [ELEM_W-1:0] elem_t;
    typedef logic [UPC_W-1:0]  upc_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_INV = 2'd2,
        OP_DOT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PP_NONE = 2'd0,
        PP_LO   = 2'd1,
        PP_HI   = 2'd2
    } pp_op_t;

    typedef enum logic {
        OPND_T1 = 1'b0,
        OPND_T2 = 1'b1
    } opnd_t;

    typedef enum logic {
        RES_SUM = 1'b0,
        RES_RED = 1'b1
    } res_t;

    typedef enum logic [1:0] {
        DST_NONE = 2'd0,
        DST_T1   = 2'd1,
        DST_T2   = 2'd2,
        DST_ACC  = 2'd3
    } dst_t;

    typedef enum logic [1:0] {
        EMIT_NONE = 2'd0,
        EMIT_RES  = 2'd1,
        EMIT_ACC  = 2'd2
    } emit_t;

    typedef struct packed {
        pp_op_t pp_op;
        opnd_t  sel_x;
        opnd_t  sel_y;
        res_t   res_sel;
        dst_t   dst;
        emit_t  emit;
        logic   cnt_load;
        logic   loop_back;
        upc_t   jump_to;
        logic   last_step;
    } ctrl_t;

    // Program entry points.
    localparam upc_t UA_ADD  = 5'd0;
    localparam upc_t UA_MUL  = 5'd1;
    localparam upc_t UA_DOT  = 5'd4;
    localparam upc_t UA_INV  = 5'd7;
    localparam upc_t UA_LOOP = 5'd10;

    localparam ctrl_t CTRL_NOP = '{
        pp_op:     PP_NONE,
        sel_x:     OPND_T1,
        sel_y:     OPND_T2,
        res_sel:   RES_RED,
        dst:       DST_NONE,
        emit:      EMIT_NONE,
        cnt_load:  1'b0,
        loop_back: 1'b0,
        jump_to:   UA_ADD,
        last_step: 1'b0
    };

    function automatic upc_t start_addr(input op_t op);
        upc_t a;
        case (op)
            OP_ADD:  a = UA_ADD;
            OP_MUL:  a = UA_MUL;
            OP_INV:  a = UA_INV;
            OP_DOT:  a = UA_DOT;
            default: a = UA_ADD;
        endcase
        return a;
    endfunction

    // Every field multiply is three steps: low partial product, high partial
    // product, then the fold of the 90-bit product into a field element.
    function automatic ctrl_t microcode(input upc_t upc);
        ctrl_t w;
        w = CTRL_NOP;
        case (upc)
            5'd0:
            begin
                w.res_sel   = RES_SUM;
                w.emit      = EMIT_RES;
                w.last_step = 1'b1;
            end
            5'd1: w.pp_op = PP_LO;
            5'd2: w.pp_op = PP_HI;
            5'd3:
            begin
                w.emit      = EMIT_RES;
                w.last_step = 1'b1;
            end
            5'd4: w.pp_op = PP_LO;
            5'd5: w.pp_op = PP_HI;
            5'd6:
            begin
                w.dst       = DST_ACC;
                w.emit      = EMIT_ACC;
                w.last_step = 1'b1;
            end
            // Inverse: t2 = t1 * t1.
            5'd7:
            begin
                w.pp_op    = PP_LO;
                w.sel_y    = OPND_T1;
                w.cnt_load = 1'b1;
            end
            5'd8:
            begin
                w.pp_op = PP_HI;
                w.sel_y = OPND_T1;
            end
            5'd9: w.dst = DST_T2;
            // Round: t1 = t1 * t2, then t2 = t2 * t2.
            5'd10: w.pp_op = PP_LO;
            5'd11: w.pp_op = PP_HI;
            5'd12: w.dst = DST_T1;
            5'd13:
            begin
                w.pp_op = PP_LO;
                w.sel_x = OPND_T2;
            end
            5'd14:
            begin
                w.pp_op = PP_HI;
                w.sel_x = OPND_T2;
            end
            5'd15:
            begin
                w.dst       = DST_T2;
                w.loop_back = 1'b1;
                w.jump_to   = UA_LOOP;
            end
            // Final squaring of t1.
            5'd16:
            begin
                w.pp_op = PP_LO;
                w.sel_y = OPND_T1;
            end
            5'd17:
            begin
                w.pp_op = PP_HI;
                w.sel_y = OPND_T1;
            end
            5'd18:
            begin
                w.emit      = EMIT_RES;
                w.last_step = 1'b1;
            end
            default: w.last_step = 1'b1;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/gfa_if.sv
// ----------------------------------------------------------------------------
// gfa_if: request and response channels of the GF(2^45) field ALU
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface gfa_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic [gfa_pkg::ELEM_W-1:0] operand_a;
    logic [gfa_pkg::ELEM_W-1:0] operand_b;
    logic                      last_term;

    modport source (output valid, output req_type, output operand_a,
                    output operand_b, output last_term, input ready);
    modport sink   (input valid, input req_type, input operand_a,
                    input operand_b, input last_term, output ready);
endinterface

interface gfa_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [gfa_pkg::ELEM_W-1:0] field_result;

    modport source (output valid, output field_result, input ready);
    modport sink   (input valid, input field_result, output ready);
endinterface

>>> rtl/core/gfa_clmul.sv
// ----------------------------------------------------------------------------
// gfa_clmul: carry-less partial product unit
// Multiplies a full field element by a 23-bit slice of the other operand.
// ----------------------------------------------------------------------------
module gfa_clmul
(
    input  logic [gfa_pkg::ELEM_W-1:0]    x,
    input  logic [gfa_pkg::HALF_LO_W-1:0] y,
    output logic [gfa_pkg::PP_W-1:0]      p
);

    logic [gfa_pkg::PP_W-1:0] x_ext;

    assign x_ext = {{(gfa_pkg::PP_W - gfa_pkg::ELEM_W){1'b0}}, x};

    always_comb
    begin
        p = '0;
        for (int i = 0; i < gfa_pkg::HALF_LO_W; i++)
        begin
            if (y[i])
            begin
                p = p ^ (x_ext << i);
            end
        end
    end

endmodule

>>> rtl/core/gfa_datapath.sv
// ----------------------------------------------------------------------------
// gfa_datapath: operand registers, product register, fold and accumulator
// Executes one control word per step when step_en is high.
// ----------------------------------------------------------------------------
module gfa_datapath
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic [gfa_pkg::ELEM_W-1:0] operand_a,
    input  logic [gfa_pkg::ELEM_W-1:0] operand_b,
    input  logic                       last_term,
    input  gfa_pkg::ctrl_t             ctrl,
    input  logic                       step_en,
    output logic                       emit_want,
    output logic [gfa_pkg::ELEM_W-1:0] emit_data
);

    gfa_pkg::elem_t             t1_reg, t1_next;
    gfa_pkg::elem_t             t2_reg, t2_next;
    gfa_pkg::elem_t             acc_reg, acc_next;
    logic [gfa_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic                       last_reg, last_next;

    gfa_pkg::elem_t                x_sel, y_sel;
    logic [gfa_pkg::HALF_LO_W-1:0] y_part;
    logic [gfa_pkg::PP_W-1:0]      pp;
    gfa_pkg::elem_t                prod_lo, prod_hi, fold_g, red, res, acc_sum;

    assign x_sel = (ctrl.sel_x == gfa_pkg::OPND_T1) ? t1_reg : t2_reg;
    assign y_sel = (ctrl.sel_y == gfa_pkg::OPND_T1) ? t1_reg : t2_reg;

    assign y_part = (ctrl.pp_op == gfa_pkg::PP_HI)
        ? {{(gfa_pkg::HALF_LO_W - gfa_pkg::HALF_HI_W){1'b0}},
           y_sel[gfa_pkg::ELEM_W-1:gfa_pkg::HALF_LO_W]}
        : y_sel[gfa_pkg::HALF_LO_W-1:0];

    gfa_clmul u_clmul
    (
        .x (x_sel),
        .y (y_part),
        .p (pp)
    );

    // Fold of the upper half: x^45 = x^4 + x^3 + x + 1, with the spill of
    // bits 41 to 44 folded back once more.
    assign prod_lo = prod_reg[gfa_pkg::ELEM_W-1:0];
    assign prod_hi = prod_reg[gfa_pkg::PROD_W-1:gfa_pkg::ELEM_W];
    assign fold_g  = prod_hi ^ (prod_hi >> (gfa_pkg::ELEM_W - 4))
                             ^ (prod_hi >> (gfa_pkg::ELEM_W - 3))
                             ^ (prod_hi >> (gfa_pkg::ELEM_W - 1));
    assign red     = prod_lo ^ (fold_g << 4) ^ (fold_g << 3) ^ (fold_g << 1) ^ fold_g;

    assign res     = (ctrl.res_sel == gfa_pkg::RES_SUM) ? (t1_reg ^ t2_reg) : red;
    assign acc_sum = acc_reg ^ res;

    always_comb
    begin
        case (ctrl.emit)
            gfa_pkg::EMIT_RES:
            begin
                emit_want = 1'b1;
                emit_data = res;
            end
            gfa_pkg::EMIT_ACC:
            begin
                emit_want = last_reg;
                emit_data = acc_sum;
            end
            default:
            begin
                emit_want = 1'b0;
                emit_data = res;
            end
        endcase
    end

    always_comb
    begin
        t1_next   = t1_reg;
        t2_next   = t2_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        last_next = last_reg;
        if (step_en)
        begin
            case (ctrl.pp_op)
                gfa_pkg::PP_LO:
                    prod_next = {{(gfa_pkg::PROD_W - gfa_pkg::PP_W){1'b0}}, pp};
                gfa_pkg::PP_HI:
                    prod_next = prod_reg ^ {pp, {gfa_pkg::HALF_LO_W{1'b0}}};
                default:
                    prod_next = prod_reg;
            endcase
            case (ctrl.dst)
                gfa_pkg::DST_T1:  t1_next = res;
                gfa_pkg::DST_T2:  t2_next = res;
                gfa_pkg::DST_ACC: acc_next = last_reg ? '0 : acc_sum;
                default:          t1_next = t1_reg;
            endcase
        end
        // Programs never write t1 or t2 in their last step, so a new item
        // may load while the previous one finishes.
        if (load)
        begin
            t1_next   = operand_a;
            t2_next   = operand_b;
            last_next = last_term;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        prod_reg <= prod_next;
        last_reg <= last_next;
    end

endmodule

>>> rtl/core/gfa_sequencer.sv
// ----------------------------------------------------------------------------
// gfa_sequencer: micro-program counter, loop counter and control ROM
// Dispatches on the operation code and steps through the program.
// ----------------------------------------------------------------------------
module gfa_sequencer
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     req_type,
    input  logic           step_en,
    output logic           busy,
    output gfa_pkg::ctrl_t ctrl
);

    logic          busy_reg, busy_next;
    gfa_pkg::upc_t upc_reg, upc_next;
    gfa_pkg::cnt_t cnt_reg, cnt_next;

    assign ctrl = gfa_pkg::microcode(upc_reg);
    assign busy = busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        cnt_next  = cnt_reg;
        if (step_en)
        begin
            if (ctrl.last_step)
            begin
                busy_next = 1'b0;
            end
            else if (ctrl.loop_back && (cnt_reg != '0))
            begin
                upc_next = ctrl.jump_to;
            end
            else
            begin
                upc_next = upc_reg + gfa_pkg::UPC_W'(1);
            end
            if (ctrl.cnt_load)
            begin
                cnt_next = gfa_pkg::CNT_W'(gfa_pkg::INV_ROUNDS - 1);
            end
            else if (ctrl.loop_back && (cnt_reg != '0))
            begin
                cnt_next = cnt_reg - gfa_pkg::CNT_W'(1);
            end
        end
        if (start)
        begin
            busy_next = 1'b1;
            upc_next  = gfa_pkg::start_addr(gfa_pkg::op_t'(req_type));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

>>> rtl/core/gf2_45_field_alu.sv
// ----------------------------------------------------------------------------
// gf2_45_field_alu: add, multiply, inverse and dot product in GF(2^45)
// Modulus x^45 + x^4 + x^3 + x + 1. A microcoded sequencer drives a datapath
// with a shared 45x23 carry-less partial product unit.
//
//   Channel  Dir  Payload                                        Moves when
//   req      in   req_type, operand_a, operand_b, last_term      valid & ready
//   rsp      out  field_result                                   valid & ready
//
// Add takes one step, so adds stream at one item per cycle unless the output
// stalls. Multiply and dot accumulate take three steps each: two passes
// through the partial product unit and one fold. Inverse runs 88 field
// multiplies. A new item is taken in the cycle the previous program ends.
// Reset clears the sequencer, output valid bit and dot accumulator. A stalled
// output holds the emitting step until the output register frees up.
// ----------------------------------------------------------------------------
module gf2_45_field_alu
(
    input  logic       clk,
    input  logic       rst_n,
    gfa_req_if.sink    req,
    gfa_rsp_if.source  rsp
);

    gfa_pkg::ctrl_t ctrl;
    logic           busy;
    logic           emit_want;
    gfa_pkg::elem_t emit_data;
    logic           out_free, step_go, step_en, accept;

    logic           out_valid_reg, out_valid_next;
    gfa_pkg::elem_t out_data_reg, out_data_next;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign step_go   = !emit_want || out_free;
    assign step_en   = busy && step_go;
    assign req.ready = !busy || (ctrl.last_step && step_go);
    assign accept    = req.valid && req.ready;

    gfa_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .req_type (req.req_type),
        .step_en  (step_en),
        .busy     (busy),
        .ctrl     (ctrl)
    );

    gfa_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .operand_a (req.operand_a),
        .operand_b (req.operand_b),
        .last_term (req.last_term),
        .ctrl      (ctrl),
        .step_en   (step_en),
        .emit_want (emit_want),
        .emit_data (emit_data)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (step_en && emit_want)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_data;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.field_result = out_data_reg;

    // An emitting step never overwrites an item still waiting at the output.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && emit_want) |-> out_free)
        else $error("result overwrote an untaken item");

    // An accepted item always starts a program.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not start the sequencer");

    // The output register fills only from an emitting step.
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step_en && emit_want))
        else $error("output became valid without an emitting step");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the GF(2^45) field ALU
// Drives add, multiply, inverse and dot-accumulate items over the request
// channel with random gaps, stalls the response channel at random, and checks
// every result against a bit-exact field arithmetic predictor in a scoreboard.
// ----------------------------------------------------------------------------
module testbench;

    localparam int             ELEM_W      = gfa_pkg::ELEM_W;
    localparam gfa_pkg::elem_t ELEM_MASK   = {ELEM_W{1'b1}};
    localparam gfa_pkg::elem_t TOP_BIT     = gfa_pkg::elem_t'(1) << (ELEM_W - 1);
    localparam int             TOTAL_ITEMS = 1850;
    localparam int             TAIL_CYCLES = 300;
    localparam int             CYCLE_LIMIT = 2000000;

    // Scoreboard: holds the field results still owed by the block and the
    // running dot product sum.
    class field_scoreboard;
        gfa_pkg::elem_t pending_results[$];
        gfa_pkg::elem_t dot_sum;
        int             mismatches;
        int             checked;

        function new();
            dot_sum    = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        // Carry-less product followed by the two-fold reduction.
        function gfa_pkg::elem_t field_mul(gfa_pkg::elem_t x, gfa_pkg::elem_t y);
            logic [2*ELEM_W-1:0] prod;
            logic [63:0]         fold;
            logic [63:0]         red;
            prod = '0;
            for (int i = 0; i < ELEM_W; i++)
                if (y[i])
                    prod ^= {{ELEM_W{1'b0}}, x} << i;
            fold = {19'b0, prod[2*ELEM_W-1:ELEM_W]};
            fold = fold ^ (fold >> 41) ^ (fold >> 42) ^ (fold >> 44);
            red  = {19'b0, prod[ELEM_W-1:0]} ^ (fold << 4) ^ (fold << 3)
                   ^ (fold << 1) ^ fold;
            return red[ELEM_W-1:0];
        endfunction

        // a^(2^45-2) by square-multiply rounds; zero stays zero.
        function gfa_pkg::elem_t field_inverse(gfa_pkg::elem_t a);
            gfa_pkg::elem_t acc;
            gfa_pkg::elem_t sq;
            acc = a;
            sq  = field_mul(a, a);
            for (int r = 0; r < gfa_pkg::INV_ROUNDS; r++)
            begin
                acc = field_mul(acc, sq);
                sq  = field_mul(sq, sq);
            end
            return field_mul(acc, acc);
        endfunction

        function void note_request(gfa_pkg::op_t op, gfa_pkg::elem_t a,
                                   gfa_pkg::elem_t b, logic last);
            case (op)
                gfa_pkg::OP_ADD: pending_results.push_back(a ^ b);
                gfa_pkg::OP_MUL: pending_results.push_back(field_mul(a, b));
                gfa_pkg::OP_INV: pending_results.push_back(field_inverse(a));
                default:
                begin
                    dot_sum ^= field_mul(a, b);
                    if (last)
                    begin
                        pending_results.push_back(dot_sum);
                        dot_sum = '0;
                    end
                end
            endcase
        endfunction

        function void check_result(gfa_pkg::elem_t actual);
            gfa_pkg::elem_t wanted;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, actual);
                mismatches++;
            end
            else
            begin
                wanted = pending_results.pop_front();
                checked++;
                if (wanted !== actual)
                begin
                    $display("%0t: field_result mismatch, expected %h, actual %h",
                             $time, wanted, actual);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    gfa_req_if req_ch();
    gfa_rsp_if rsp_ch();

    gf2_45_field_alu u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    field_scoreboard sb = new();

    int items_sent = 0;
    int op_count[4] = '{0, 0, 0, 0};
    int cycles = 0;
    bit no_gaps = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycles, sb.pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_result(rsp_ch.field_result);
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic gfa_pkg::elem_t rand_elem();
        logic [63:0] w;
        case ($urandom_range(0, 15))
            0: return '0;
            1: return gfa_pkg::elem_t'(1);
            2: return ELEM_MASK;
            3: return gfa_pkg::elem_t'(1) << $urandom_range(0, ELEM_W - 1);
            default:
            begin
                w = {$urandom, $urandom};
                return w[ELEM_W-1:0];
            end
        endcase
    endfunction

    task automatic send_item(input gfa_pkg::op_t op, input gfa_pkg::elem_t a,
                             input gfa_pkg::elem_t b, input logic last);
        int gap;
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.operand_a <= a;
        req_ch.operand_b <= b;
        req_ch.last_term <= last;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(op, a, b, last);
        items_sent++;
        op_count[op]++;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Response side: bursts of ready broken by random stalls.
    initial
    begin
        int burst;
        int gap;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 12);
            rsp_ch.ready <= 1'b1;
            repeat (burst) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        int  pick;
        int  len;
        bit  drained_mid;
        drained_mid      = 1'b0;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = gfa_pkg::OP_ADD;
        req_ch.operand_a = '0;
        req_ch.operand_b = '0;
        req_ch.last_term = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items: operand extremes, every operation, last flag on
        // operations that ignore it, and dot sequences broken by other items.
        send_item(gfa_pkg::OP_ADD, '0, '0, 1'b0);
        send_item(gfa_pkg::OP_ADD, ELEM_MASK, ELEM_MASK, 1'b0);
        send_item(gfa_pkg::OP_ADD, ELEM_MASK, '0, 1'b1);
        send_item(gfa_pkg::OP_MUL, '0, rand_elem(), 1'b0);
        send_item(gfa_pkg::OP_MUL, gfa_pkg::elem_t'(1), rand_elem(), 1'b0);
        send_item(gfa_pkg::OP_MUL, ELEM_MASK, ELEM_MASK, 1'b0);
        send_item(gfa_pkg::OP_MUL, TOP_BIT, TOP_BIT, 1'b0);
        send_item(gfa_pkg::OP_MUL, rand_elem(), rand_elem(), 1'b1);
        send_item(gfa_pkg::OP_MUL, ELEM_MASK, gfa_pkg::elem_t'(1), 1'b0);
        send_item(gfa_pkg::OP_INV, '0, rand_elem(), 1'b0);
        send_item(gfa_pkg::OP_INV, gfa_pkg::elem_t'(1), '0, 1'b0);
        send_item(gfa_pkg::OP_INV, ELEM_MASK, ELEM_MASK, 1'b0);
        send_item(gfa_pkg::OP_INV, TOP_BIT, rand_elem(), 1'b1);
        send_item(gfa_pkg::OP_INV, rand_elem(), rand_elem(), 1'b0);
        send_item(gfa_pkg::OP_DOT, rand_elem(), rand_elem(), 1'b0);
        send_item(gfa_pkg::OP_DOT, ELEM_MASK, ELEM_MASK, 1'b0);
        send_item(gfa_pkg::OP_ADD, rand_elem(), rand_elem(), 1'b1);
        send_item(gfa_pkg::OP_DOT, TOP_BIT, rand_elem(), 1'b1);
        send_item(gfa_pkg::OP_DOT, gfa_pkg::elem_t'(1), rand_elem(), 1'b1);
        send_item(gfa_pkg::OP_DOT, '0, '0, 1'b0);
        send_item(gfa_pkg::OP_DOT, '0, ELEM_MASK, 1'b1);
        drain_results();

        while (items_sent < TOTAL_ITEMS)
        begin
            if (!drained_mid && items_sent >= TOTAL_ITEMS / 2)
            begin
                drain_results();
                drained_mid = 1'b1;
            end
            if ($urandom_range(0, 39) == 0)
                no_gaps = ~no_gaps;
            pick = $urandom_range(0, 99);
            if (pick < 22)
                send_item(gfa_pkg::OP_ADD, rand_elem(), rand_elem(),
                          1'($urandom_range(0, 1)));
            else if (pick < 50)
                send_item(gfa_pkg::OP_MUL, rand_elem(), rand_elem(),
                          1'($urandom_range(0, 1)));
            else if (pick < 56)
                send_item(gfa_pkg::OP_INV, rand_elem(), rand_elem(),
                          1'($urandom_range(0, 1)));
            else if (pick < 92)
            begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len - 1; k++)
                    send_item(gfa_pkg::OP_DOT, rand_elem(), rand_elem(), 1'b0);
                send_item(gfa_pkg::OP_DOT, rand_elem(), rand_elem(), 1'b1);
            end
            else
            begin
                // A dot sequence cut short by another operation; the partial
                // sum carries into the next sequence.
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    send_item(gfa_pkg::OP_DOT, rand_elem(), rand_elem(), 1'b0);
                send_item(gfa_pkg::op_t'($urandom_range(0, 2)), rand_elem(), rand_elem(),
                          1'b1);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.pending_results.size() != 0)
            $display("%0t: %0d expected results never arrived",
                     $time, sb.pending_results.size());
        $display("Sent %0d items: %0d add, %0d multiply, %0d inverse, %0d dot terms.",
                 items_sent, op_count[gfa_pkg::OP_ADD], op_count[gfa_pkg::OP_MUL],
                 op_count[gfa_pkg::OP_INV], op_count[gfa_pkg::OP_DOT]);
        $display("Checked %0d results under random gaps and output stalls, %0d mismatches.",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
